FILE: src/pccs_pkg.sv
// ============================================================================
// pccs_pkg: shared types and constants of the power cycle color sequencer
// Holds the sequencer phase codes, request codes, register indexes and the
// state, configuration and result structs passed between modules.
// ============================================================================
package pccs_pkg;

    // Number of programmable reset step registers, and the cap on steps played.
    localparam int unsigned NUM_RESET_REGS  = 4;
    localparam int unsigned MAX_RESET_STEPS = 4;

    // Request codes on the func field.
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_REQUEST = 2'd1;
    localparam logic [1:0] FUNC_RESET   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_COLOR_COUNT = 3'd0;
    localparam logic [2:0] CFG_MIN_OFF     = 3'd1;
    localparam logic [2:0] CFG_CHANGE      = 3'd2;
    localparam logic [2:0] CFG_STEP_COUNT  = 3'd3;
    localparam logic [2:0] CFG_STEP_A      = 3'd4;
    localparam logic [2:0] CFG_STEP_B      = 3'd5;
    localparam logic [2:0] CFG_STEP_C      = 3'd6;
    localparam logic [2:0] CFG_STEP_D      = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PRE_OFF = 3'd1,
        PH_OFF     = 3'd2,
        PH_FINAL   = 3'd3,
        PH_RESET   = 3'd4
    } phase_t;

    typedef struct packed {
        logic        switch_level;
        logic [31:0] off_elapsed;
        logic        turn_on_pending;
        logic        held_on;
        logic [7:0]  held_effect;
        logic [7:0]  present_color;
        phase_t      phase;
        logic [31:0] phase_timer;
        logic [2:0]  reset_step_pos;
        logic        sync_flag;
    } state_t;

    typedef struct packed {
        logic [7:0]                       color_count;
        logic [31:0]                      min_off_ticks;
        logic [31:0]                      change_ticks;
        logic [2:0]                       reset_step_count;
        logic [NUM_RESET_REGS-1:0][32:0]  reset_step;
    } cfg_t;

    typedef struct packed {
        logic        output_on;
        logic [7:0]  color_now;
        logic        busy_res;
        logic        effect_sync;
    } result_t;

endpackage

FILE: src/pccs_step.sv
// ============================================================================
// pccs_step: next-state logic for one item
// Combinational update of the sequencer state for a tick, a request update
// or a color reset command, plus the result fields seen after the update.
// ============================================================================
module pccs_step (
    input  pccs_pkg::state_t  state_cur,
    input  pccs_pkg::cfg_t    cfg,
    input  logic [1:0]        func,
    input  logic              want_on,
    input  logic [7:0]        effect_request,
    output pccs_pkg::state_t  state_next,
    output pccs_pkg::result_t result
);

    // Out-of-range color reads as 1 and is written back as such.
    function automatic pccs_pkg::state_t norm_color(pccs_pkg::state_t s);
        pccs_pkg::state_t r;
        r = s;
        if (r.present_color == 8'd0 || r.present_color > cfg.color_count)
        begin
            r.present_color = 8'd1;
        end
        return r;
    endfunction

    function automatic pccs_pkg::state_t drive(pccs_pkg::state_t s, logic level);
        pccs_pkg::state_t r;
        r = s;
        if (r.switch_level && !level)
        begin
            r.off_elapsed = 32'd0;
        end
        r.switch_level = level;
        return r;
    endfunction

    function automatic logic effect_in_range(pccs_pkg::state_t s);
        return (s.held_effect != 8'd0) && (s.held_effect <= cfg.color_count);
    endfunction

    function automatic pccs_pkg::state_t apply_request(pccs_pkg::state_t s);
        pccs_pkg::state_t r;
        r = s;
        if (r.phase == pccs_pkg::PH_IDLE)
        begin
            if (!r.held_on)
            begin
                r.turn_on_pending = 1'b0;
                r = drive(r, 1'b0);
            end
            else if (!r.switch_level && r.off_elapsed < cfg.min_off_ticks)
            begin
                r.turn_on_pending = 1'b1;
            end
            else
            begin
                r.turn_on_pending = 1'b0;
                r = drive(r, 1'b1);
                r = norm_color(r);
                if (r.held_effect == 8'd0)
                begin
                    r.held_effect = r.present_color;
                    r.sync_flag   = 1'b1;
                end
                else if (effect_in_range(r) && r.held_effect != r.present_color)
                begin
                    r.phase       = pccs_pkg::PH_PRE_OFF;
                    r.phase_timer = cfg.change_ticks;
                end
            end
        end
        return r;
    endfunction

    function automatic pccs_pkg::state_t next_reset_step(pccs_pkg::state_t s);
        pccs_pkg::state_t r;
        logic [2:0]       n;
        logic [32:0]      stp;
        r = s;
        n = cfg.reset_step_count;
        if (n > 3'(pccs_pkg::MAX_RESET_STEPS))
        begin
            n = 3'(pccs_pkg::MAX_RESET_STEPS);
        end
        stp = cfg.reset_step[r.reset_step_pos[1:0]];
        if (r.reset_step_pos < n)
        begin
            r.reset_step_pos = r.reset_step_pos + 3'd1;
            r = drive(r, stp[32]);
            r.phase       = pccs_pkg::PH_RESET;
            r.phase_timer = stp[31:0];
        end
        else
        begin
            r.present_color = 8'd1;
            r.phase         = pccs_pkg::PH_IDLE;
            r = apply_request(r);
        end
        return r;
    endfunction

    function automatic pccs_pkg::state_t phase_done(pccs_pkg::state_t s);
        pccs_pkg::state_t r;
        logic [7:0]       target;
        r = s;
        case (r.phase)
            pccs_pkg::PH_PRE_OFF:
            begin
                r = drive(r, 1'b0);
                r.phase       = pccs_pkg::PH_OFF;
                r.phase_timer = cfg.change_ticks;
            end
            pccs_pkg::PH_OFF:
            begin
                r = drive(r, 1'b1);
                r = norm_color(r);
                r.present_color = (r.present_color < cfg.color_count) ?
                                  r.present_color + 8'd1 : 8'd1;
                if (effect_in_range(r))
                begin
                    target = r.held_effect;
                end
                else
                begin
                    r = norm_color(r);
                    target = r.present_color;
                end
                if (r.present_color != target)
                begin
                    r.phase       = pccs_pkg::PH_PRE_OFF;
                    r.phase_timer = cfg.change_ticks;
                end
                else if (r.held_on)
                begin
                    r.phase = pccs_pkg::PH_IDLE;
                end
                else
                begin
                    r.phase       = pccs_pkg::PH_FINAL;
                    r.phase_timer = cfg.change_ticks;
                end
            end
            pccs_pkg::PH_FINAL:
            begin
                r.phase = pccs_pkg::PH_IDLE;
                r = apply_request(r);
            end
            pccs_pkg::PH_RESET:
            begin
                r = next_reset_step(r);
            end
            default:
            begin
                r.phase = pccs_pkg::PH_IDLE;
            end
        endcase
        return r;
    endfunction

    function automatic pccs_pkg::state_t tick(pccs_pkg::state_t s);
        pccs_pkg::state_t r;
        r = s;
        if (!r.switch_level && r.off_elapsed != 32'hFFFF_FFFF)
        begin
            r.off_elapsed = r.off_elapsed + 32'd1;
        end
        if (r.phase != pccs_pkg::PH_IDLE)
        begin
            if (r.phase_timer != 32'd0)
            begin
                r.phase_timer = r.phase_timer - 32'd1;
            end
            if (r.phase_timer == 32'd0)
            begin
                r = phase_done(r);
            end
        end
        // Pending turn-on only exists while idle, so at most one apply per item.
        if (r.turn_on_pending && (r.switch_level || r.off_elapsed >= cfg.min_off_ticks))
        begin
            r.turn_on_pending = 1'b0;
            r = apply_request(r);
        end
        return r;
    endfunction

    always_comb
    begin
        pccs_pkg::state_t s;
        s = state_cur;
        s.sync_flag = 1'b0;
        case (func)
            pccs_pkg::FUNC_TICK:
            begin
                s = tick(s);
            end
            pccs_pkg::FUNC_REQUEST:
            begin
                s.held_on     = want_on;
                s.held_effect = effect_request;
                s = apply_request(s);
            end
            pccs_pkg::FUNC_RESET:
            begin
                if (s.phase == pccs_pkg::PH_IDLE)
                begin
                    s.turn_on_pending = 1'b0;
                    s.reset_step_pos  = 3'd0;
                    s.phase           = pccs_pkg::PH_RESET;
                    s = next_reset_step(s);
                end
            end
            default:
            begin
                s = s;
            end
        endcase
        state_next         = s;
        result.output_on   = s.switch_level;
        result.color_now   = s.present_color;
        result.busy_res    = (s.phase != pccs_pkg::PH_IDLE);
        result.effect_sync = s.sync_flag;
    end

endmodule

FILE: src/power_cycle_color_sequencer.sv
// ============================================================================
// power_cycle_color_sequencer: power switch driver for a color-cycling light
// Top level: configuration registers, input register, sequencer state and
// result register around the single-item next-state logic.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one item per accept: func
//   selects a tick, a request update (want_on, effect_request) or a color
//   reset command. Every accepted item yields exactly one result item on the
//   output channel (out_valid / out_stall): switch level, believed color,
//   busy flag and effect sync flag after that item.
//   An accepted item sits in the input register; the whole state update then
//   runs combinationally from there into the result register, where out_valid
//   rises. Throughput is one item per clock while the receiver does not stall;
//   the single state register loop (tick counters, phase timer, color) closes
//   through the combinational next-state logic.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more item, after which in_stall follows out_stall.
//   Configuration writes (cfg_write, cfg_index, cfg_data) are registered; the
//   user must make them only while no item is in flight: the block never checks.
//   Reset (rst_n low, async) clears both channels, puts the switch off with
//   the off period starting, color 1, no held request, and restores the
//   register defaults (one color, all times zero, no reset steps).
module power_cycle_color_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [32:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic        want_on,
    input  logic [7:0]  effect_request,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        output_on,
    output logic [7:0]  color_now,
    output logic        busy_res,
    output logic        effect_sync
);

    pccs_pkg::cfg_t     cfg_reg;
    pccs_pkg::state_t   state_reg;
    pccs_pkg::state_t   state_next;
    pccs_pkg::result_t  result_next;
    pccs_pkg::result_t  result_reg;

    logic        inq_valid_reg;
    logic [1:0]  inq_func_reg;
    logic        inq_want_on_reg;
    logic [7:0]  inq_effect_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        fire;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_count      <= 8'd1;
            cfg_reg.min_off_ticks    <= 32'd0;
            cfg_reg.change_ticks     <= 32'd0;
            cfg_reg.reset_step_count <= 3'd0;
            cfg_reg.reset_step       <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pccs_pkg::CFG_COLOR_COUNT: cfg_reg.color_count      <= cfg_data[7:0];
                pccs_pkg::CFG_MIN_OFF:     cfg_reg.min_off_ticks    <= cfg_data[31:0];
                pccs_pkg::CFG_CHANGE:      cfg_reg.change_ticks     <= cfg_data[31:0];
                pccs_pkg::CFG_STEP_COUNT:  cfg_reg.reset_step_count <= cfg_data[2:0];
                pccs_pkg::CFG_STEP_A:      cfg_reg.reset_step[0]    <= cfg_data;
                pccs_pkg::CFG_STEP_B:      cfg_reg.reset_step[1]    <= cfg_data;
                pccs_pkg::CFG_STEP_C:      cfg_reg.reset_step[2]    <= cfg_data;
                pccs_pkg::CFG_STEP_D:      cfg_reg.reset_step[3]    <= cfg_data;
                default:                   cfg_reg.color_count      <= cfg_reg.color_count;
            endcase
        end
    end

    // ---------------- handshake ----------------
    // The compute stage moves when the result register is empty or draining.
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = inq_valid_reg && advance;
    assign in_stall = inq_valid_reg && !advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            inq_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            inq_func_reg    <= func;
            inq_want_on_reg <= want_on;
            inq_effect_reg  <= effect_request;
        end
    end

    // ---------------- next-state logic ----------------
    pccs_step u_step (
        .state_cur      (state_reg),
        .cfg            (cfg_reg),
        .func           (inq_func_reg),
        .want_on        (inq_want_on_reg),
        .effect_request (inq_effect_reg),
        .state_next     (state_next),
        .result         (result_next)
    );

    // sequencer state: updated once per item as it passes to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.switch_level    <= 1'b0;
            state_reg.off_elapsed     <= 32'd0;
            state_reg.turn_on_pending <= 1'b0;
            state_reg.held_on         <= 1'b0;
            state_reg.held_effect     <= 8'd0;
            state_reg.present_color   <= 8'd1;
            state_reg.phase           <= pccs_pkg::PH_IDLE;
            state_reg.phase_timer     <= 32'd0;
            state_reg.reset_step_pos  <= 3'd0;
            state_reg.sync_flag       <= 1'b0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign output_on   = result_reg.output_on;
    assign color_now   = result_reg.color_now;
    assign busy_res    = result_reg.busy_res;
    assign effect_sync = result_reg.effect_sync;

`ifndef ASSERT_OFF
    // A deferred turn-on is only ever held while no sequence runs.
    a_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.turn_on_pending |-> (state_reg.phase == pccs_pkg::PH_IDLE))
        else $error("turn-on pending while sequence busy");

    // Color is only set to 1, normalized or advanced below the color count, so it never reaches zero.
    a_color_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.present_color != 8'd0)
        else $error("present color is zero");

    a_step_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.reset_step_pos <= 3'(pccs_pkg::MAX_RESET_STEPS))
        else $error("reset step position past cap");

    // An item leaving the input register shows up as a result next cycle.
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("item lost between input and result register");
`endif

endmodule
